// ----- rtl/ue2u_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ue2u_pkg: shared types and constants for the escape-to-UTF-8 decoder
// Holds the payload structs, the job word passed from front to back, the
// parser mode encoding and the character and UTF-8 constants.
// ----------------------------------------------------------------------------
package ue2u_pkg;

  // Lanes in one job: up to ten escape characters plus one trailing character.
  localparam int NUM_LANES       = 11;
  localparam int ESC_DIGITS      = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Character codes that steer the parser.
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_LOWER_U = 8'h75;
  localparam logic [7:0] CH_UPPER_U = 8'h55;

  // UTF-8 range limits and byte prefixes.
  localparam logic [31:0] CP_MAX1  = 32'h0000_007F;
  localparam logic [31:0] CP_MAX2  = 32'h0000_07FF;
  localparam logic [31:0] CP_MAX3  = 32'h0000_FFFF;
  localparam logic [31:0] CP_MAX4  = 32'h0010_FFFF;
  localparam logic [7:0]  LEAD2    = 8'hC0;
  localparam logic [7:0]  LEAD3    = 8'hE0;
  localparam logic [7:0]  LEAD4    = 8'hF0;
  localparam logic [7:0]  CONT     = 8'h80;
  localparam logic [7:0]  CONT_MSK = 8'h3F;

  // Parser mode.
  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_SHORT,
    MODE_LONG
  } mode_t;

  // Input transfer payload.
  typedef struct packed {
    logic [7:0] char_in;
    logic       string_last;
  } text_t;

  // Output transfer payload.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;
    logic       range_error;
  } utf_t;

  // One input character's worth of output: bytes with a lane mask. An empty
  // mask with last set is a bare end marker.
  typedef struct packed {
    logic [NUM_LANES-1:0][7:0] bytes;
    logic [NUM_LANES-1:0]      mask;
    logic                      last;
    logic                      err;
  } job_t;

endpackage

// ----- rtl/unicode_escape_to_utf8.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unicode_escape_to_utf8: escape sequence to UTF-8 decoder, top level
// Path: the results of a character pass through the job queue, the
//   emitter's job register and the output register.
// Throughput: one character per cycle while each yields at most one byte
//   and the output is not stalled; the emitter sends one result per cycle
//   while unstalled, and the queue absorbs a character with several results.
// Reset: synchronous, clears the parser, the queue and the output valid.
// ----------------------------------------------------------------------------
module unicode_escape_to_utf8 #(
  parameter int QUEUE_DEPTH = ue2u_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             text_valid,
  input  ue2u_pkg::text_t  text,
  output logic             text_stall,
  output logic             utf_valid,
  output ue2u_pkg::utf_t   utf,
  input  logic             utf_stall
);
  import ue2u_pkg::*;

  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  // Parser.
  ue2u_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text       (text),
    .text_stall (text_stall),
    .q_full     (q_full),
    .push       (push),
    .job        (push_job)
  );

  // Job queue.
  ue2u_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Emitter.
  ue2u_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .utf_valid  (utf_valid),
    .utf        (utf),
    .utf_stall  (utf_stall)
  );

endmodule

// ----- rtl/ue2u_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ue2u_front: escape parser
// Takes one character per cycle while the job queue is not full, tracks
// the escape state and turns each character into a job word listing its bytes.
// ----------------------------------------------------------------------------
module ue2u_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             text_valid,
  input  ue2u_pkg::text_t  text,
  output logic             text_stall,
  input  logic             q_full,
  output logic             push,
  output ue2u_pkg::job_t   job
);
  import ue2u_pkg::*;

  mode_t       mode, mode_next;
  logic [3:0]  dc, dc_next;
  logic [31:0] acc, acc_next;
  logic        err_seen, err_next;
  logic [7:0]  digits [ESC_DIGITS];

  logic        accept;
  logic [7:0]  c;
  logic        last;
  logic        is_hex;
  logic [3:0]  hex_val;
  logic [31:0] acc_shift;
  logic [3:0]  dc_inc;
  logic        digit_done;
  logic        cp_ok;
  logic        digit_wr;

  logic [3:0]  flush_len;
  logic [3:0][7:0] dbytes;
  logic [3:0]  dmask;
  logic        tail;
  logic [7:0]  dig_view [ESC_DIGITS];
  logic [9:0][7:0] esc_text;

  assign c          = text.char_in;
  assign last       = text.string_last;
  assign text_stall = q_full;
  assign accept     = text_valid && !q_full;

  // Hex digit decode.
  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hex_val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hex_val = 4'(c - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  // Shared datapath of the digit states.
  assign acc_shift  = {acc[27:0], hex_val};
  assign dc_inc     = dc + 4'd1;
  assign digit_done = (mode == MODE_SHORT && dc_inc == 4'd4) ||
                      (mode == MODE_LONG && dc_inc == 4'd8);
  assign cp_ok      = acc_shift <= CP_MAX4;
  assign digit_wr   = (mode == MODE_SHORT || mode == MODE_LONG) && is_hex;

  // Next state of the parser, before the end-of-string clear.
  always_comb begin
    mode_next = mode;
    dc_next   = dc;
    acc_next  = acc;
    err_next  = err_seen;
    unique case (mode) inside
      MODE_PLAIN: begin
        if (c == CH_BSLASH) begin
          mode_next = MODE_ESC;
          dc_next   = 4'd0;
          acc_next  = '0;
        end
      end
      MODE_ESC: begin
        dc_next  = 4'd0;
        acc_next = '0;
        if (c == CH_LOWER_U) begin
          mode_next = MODE_SHORT;
        end else if (c == CH_UPPER_U) begin
          mode_next = MODE_LONG;
        end else begin
          mode_next = MODE_PLAIN;
        end
      end
      MODE_SHORT, MODE_LONG: begin
        if (!is_hex) begin
          mode_next = (c == CH_BSLASH) ? MODE_ESC : MODE_PLAIN;
          dc_next   = 4'd0;
          acc_next  = '0;
        end else if (digit_done) begin
          mode_next = MODE_PLAIN;
          dc_next   = 4'd0;
          acc_next  = '0;
          if (!cp_ok) begin
            err_next = 1'b1;
          end
        end else begin
          acc_next = acc_shift;
          dc_next  = dc_inc;
        end
      end
      default: begin
        mode_next = MODE_PLAIN;
      end
    endcase
  end

  // Escape text as it stands including this character's digit.
  always_comb begin
    for (int i = 0; i < ESC_DIGITS; i++) begin
      dig_view[i] = (digit_wr && dc[2:0] == 3'(i)) ? c : digits[i];
    end
    esc_text[0] = CH_BSLASH;
    if (mode == MODE_ESC) begin
      esc_text[1] = c;
    end else if (mode == MODE_SHORT) begin
      esc_text[1] = CH_LOWER_U;
    end else begin
      esc_text[1] = CH_UPPER_U;
    end
    for (int i = 0; i < ESC_DIGITS; i++) begin
      esc_text[i + 2] = dig_view[i];
    end
  end

  // Bytes produced by this character.
  always_comb begin
    flush_len = 4'd0;
    dbytes    = '0;
    dmask     = 4'b0000;
    tail      = 1'b0;
    unique case (mode) inside
      MODE_PLAIN: begin
        if (c != CH_BSLASH) begin
          dbytes[0] = c;
          dmask     = 4'b0001;
        end else if (last) begin
          flush_len = 4'd1;
        end
      end
      MODE_ESC: begin
        if (c == CH_LOWER_U || c == CH_UPPER_U) begin
          if (last) begin
            flush_len = 4'd2;
          end
        end else begin
          dbytes[0] = CH_BSLASH;
          dbytes[1] = c;
          dmask     = {2'b00, c != CH_BSLASH, c != CH_QUOTE};
        end
      end
      MODE_SHORT, MODE_LONG: begin
        if (!is_hex) begin
          // Bad digit: escape text goes out, then c unless it opens an escape.
          flush_len = 4'd2 + dc;
          tail      = (c != CH_BSLASH) || last;
        end else if (digit_done) begin
          if (!cp_ok) begin
            flush_len = 4'd10;
          end else if (acc_shift <= CP_MAX1) begin
            dbytes[0] = acc_shift[7:0];
            dmask     = 4'b0001;
          end else if (acc_shift <= CP_MAX2) begin
            dbytes[0] = LEAD2 | {3'b000, acc_shift[10:6]};
            dbytes[1] = CONT | ({2'b00, acc_shift[5:0]} & CONT_MSK);
            dmask     = 4'b0011;
          end else if (acc_shift <= CP_MAX3) begin
            dbytes[0] = LEAD3 | {4'b0000, acc_shift[15:12]};
            dbytes[1] = CONT | {2'b00, acc_shift[11:6]};
            dbytes[2] = CONT | {2'b00, acc_shift[5:0]};
            dmask     = 4'b0111;
          end else begin
            dbytes[0] = LEAD4 | {5'b00000, acc_shift[20:18]};
            dbytes[1] = CONT | {2'b00, acc_shift[17:12]};
            dbytes[2] = CONT | {2'b00, acc_shift[11:6]};
            dbytes[3] = CONT | {2'b00, acc_shift[5:0]};
            dmask     = 4'b1111;
          end
        end else if (last) begin
          flush_len = 4'd2 + dc_inc;
        end
      end
      default: begin
        flush_len = 4'd0;
      end
    endcase
  end

  // Job assembly; zero bytes are masked off here.
  always_comb begin
    job.last = last;
    job.err  = err_next;
    for (int i = 0; i < 10; i++) begin
      if (flush_len != 4'd0) begin
        job.bytes[i] = esc_text[i];
        job.mask[i]  = 4'(i) < flush_len;
      end else if (i < 4) begin
        job.bytes[i] = dbytes[i];
        job.mask[i]  = dmask[i] && (dbytes[i] != 8'h00);
      end else begin
        job.bytes[i] = 8'h00;
        job.mask[i]  = 1'b0;
      end
    end
    job.bytes[NUM_LANES-1] = c;
    job.mask[NUM_LANES-1]  = tail && (c != 8'h00);
  end

  assign push = accept && ((job.mask != '0) || last);

  // Parser state registers; the end of a string returns everything to reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_PLAIN;
      dc       <= 4'd0;
      acc      <= '0;
      err_seen <= 1'b0;
    end else if (accept) begin
      if (last) begin
        mode     <= MODE_PLAIN;
        dc       <= 4'd0;
        acc      <= '0;
        err_seen <= 1'b0;
      end else begin
        mode     <= mode_next;
        dc       <= dc_next;
        acc      <= acc_next;
        err_seen <= err_next;
      end
    end
  end

  // Digit text of the current escape.
  always_ff @(posedge clk) begin
    if (accept && digit_wr) begin
      digits[dc[2:0]] <= c;
    end
  end

  a_clear_at_end: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> mode == MODE_PLAIN && !err_seen && dc == 4'd0)
    else $error("parser state not cleared after the end of a string");

  a_no_digits_outside: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_PLAIN || mode == MODE_ESC) |-> dc == 4'd0)
    else $error("digit count set outside a hex escape");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("job pushed into a full queue");

endmodule

// ----- rtl/ue2u_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ue2u_queue: job queue
// Short first-in first-out buffer of job words between parser and emitter.
// ----------------------------------------------------------------------------
module ue2u_queue #(
  parameter int DEPTH = ue2u_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ue2u_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output ue2u_pkg::job_t  head_job
);
  import ue2u_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full       = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head_job   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from an empty queue");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + CW'(1))
    else $error("queue count did not follow a push");

endmodule

// ----- rtl/ue2u_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ue2u_back: byte emitter
// Walks the lanes of one job at a time and sends one result per cycle
// through an output register while the output is not stalled.
// ----------------------------------------------------------------------------
module ue2u_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  ue2u_pkg::job_t  head_job,
  output logic            pop,
  output logic            utf_valid,
  output ue2u_pkg::utf_t  utf,
  input  logic            utf_stall
);
  import ue2u_pkg::*;

  job_t                 cur;
  logic                 cur_busy;
  logic [NUM_LANES-1:0] low;
  logic [NUM_LANES-1:0] rest;
  logic [7:0]           sel_byte;
  logic                 out_free;
  logic                 fire;
  logic                 done;

  // Lowest pending lane and what remains after it.
  always_comb begin
    low      = cur.mask & (~cur.mask + NUM_LANES'(1));
    rest     = cur.mask & ~low;
    sel_byte = 8'h00;
    for (int i = 0; i < NUM_LANES; i++) begin
      sel_byte = sel_byte | (cur.bytes[i] & {8{low[i]}});
    end
  end

  assign out_free = !utf_valid || !utf_stall;
  assign fire     = cur_busy && out_free;
  assign done     = fire && (rest == '0);
  assign pop      = head_valid && (!cur_busy || done);

  // Current job register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_busy <= 1'b0;
    end else if (pop) begin
      cur_busy <= 1'b1;
    end else if (done) begin
      cur_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_job;
    end else if (fire) begin
      cur.mask <= rest;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      utf_valid <= 1'b0;
    end else if (fire) begin
      utf_valid <= 1'b1;
    end else if (!utf_stall) begin
      utf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      utf.out_byte    <= sel_byte;
      utf.byte_valid  <= cur.mask != '0;
      utf.run_last    <= rest == '0;
      utf.string_end  <= (rest == '0) && cur.last;
      utf.range_error <= cur.err;
    end
  end

  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    cur_busy && cur.mask == '0 |-> cur.last)
    else $error("empty job that does not end a string");

  a_marker_shape: assert property (@(posedge clk) disable iff (rst)
    utf_valid && !utf.byte_valid |-> utf.run_last && utf.string_end)
    else $error("end marker without run and string end");

  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    utf_valid && utf.string_end |-> utf.run_last)
    else $error("string end on a result that is not the last of its run");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the escape sequence to UTF-8 decoder
// Drives whole strings of characters, short and long Unicode escapes, simple
// escapes, broken escapes and raw bytes, and checks every output transfer
// against a behavioral decoder kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb;
  import ue2u_pkg::*;

  // Behavioral decoder plus the queue of output transfers it predicts.
  class utf8_decode_pred;
    mode_t       mode;
    logic [3:0]  digit_cnt;
    logic [31:0] code_point;
    logic [7:0]  esc_text [10];
    logic        err_flag;
    logic [7:0]  burst [$];
    utf_t        utf_q [$];
    int          fails;

    function new();
      mode       = MODE_PLAIN;
      digit_cnt  = '0;
      code_point = '0;
      err_flag   = 1'b0;
      fails      = 0;
      foreach (esc_text[i]) esc_text[i] = '0;
    endfunction

    // Zero bytes are never sent.
    function void put_byte(logic [7:0] b);
      if (b != 8'h00) burst.push_back(b);
    endfunction

    function void clear_escape();
      mode       = MODE_PLAIN;
      digit_cnt  = '0;
      code_point = '0;
    endfunction

    // Send the escape text seen so far as literal characters.
    function void flush_escape();
      int len = 0;
      if (mode == MODE_ESC) len = 1;
      else if (mode == MODE_SHORT || mode == MODE_LONG) len = 2 + digit_cnt;
      if (len > 10) len = 10;
      for (int k = 0; k < len; k++) put_byte(esc_text[k]);
      clear_escape();
    endfunction

    // Encode the finished code point, or flag it when it is out of range.
    function void encode_point();
      if (code_point <= CP_MAX1) begin
        put_byte(code_point[7:0]);
      end else if (code_point <= CP_MAX2) begin
        put_byte(LEAD2 | {3'b000, code_point[10:6]});
        put_byte(CONT | {2'b00, code_point[5:0]});
      end else if (code_point <= CP_MAX3) begin
        put_byte(LEAD3 | {4'b0000, code_point[15:12]});
        put_byte(CONT | {2'b00, code_point[11:6]});
        put_byte(CONT | {2'b00, code_point[5:0]});
      end else if (code_point <= CP_MAX4) begin
        put_byte(LEAD4 | {5'b00000, code_point[20:18]});
        put_byte(CONT | {2'b00, code_point[17:12]});
        put_byte(CONT | {2'b00, code_point[11:6]});
        put_byte(CONT | {2'b00, code_point[5:0]});
      end else begin
        err_flag = 1'b1;
        flush_escape();
        return;
      end
      clear_escape();
    endfunction

    function void plain_char(logic [7:0] c);
      if (c == CH_BSLASH) begin
        esc_text[0] = c;
        mode        = MODE_ESC;
        digit_cnt   = '0;
        code_point  = '0;
      end else begin
        put_byte(c);
      end
    endfunction

    function int hex_val(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
    endfunction

    // Predict the output transfers caused by one accepted character.
    function void note_text(text_t t);
      logic [7:0] c;
      int         v;
      int         n;
      utf_t       r;
      c = t.char_in;
      burst.delete();
      case (mode)
        MODE_PLAIN: plain_char(c);
        MODE_ESC: begin
          if (c == CH_LOWER_U || c == CH_UPPER_U) begin
            esc_text[1] = c;
            if (c == CH_LOWER_U) mode = MODE_SHORT;
            else mode = MODE_LONG;
            digit_cnt  = '0;
            code_point = '0;
          end else begin
            if (c != CH_QUOTE) put_byte(CH_BSLASH);
            if (c != CH_BSLASH) put_byte(c);
            mode = MODE_PLAIN;
          end
        end
        default: begin
          v = hex_val(c);
          if (v < 0) begin
            flush_escape();
            plain_char(c);
          end else begin
            esc_text[2 + digit_cnt[2:0]] = c;
            code_point = {code_point[27:0], v[3:0]};
            digit_cnt  = digit_cnt + 4'd1;
            if (digit_cnt >= ((mode == MODE_SHORT) ? 4'd4 : 4'd8)) encode_point();
          end
        end
      endcase
      if (t.string_last && mode != MODE_PLAIN) flush_escape();

      // A final character with no byte still ends the string with a marker.
      n = burst.size();
      if (n == 0 && t.string_last) begin
        r.out_byte    = 8'h00;
        r.byte_valid  = 1'b0;
        r.run_last    = 1'b1;
        r.string_end  = 1'b1;
        r.range_error = err_flag;
        utf_q.push_back(r);
      end
      for (int k = 0; k < n; k++) begin
        r.out_byte    = burst[k];
        r.byte_valid  = 1'b1;
        r.run_last    = (k == n - 1);
        r.string_end  = t.string_last && (k == n - 1);
        r.range_error = err_flag;
        utf_q.push_back(r);
      end
      if (t.string_last) begin
        clear_escape();
        err_flag = 1'b0;
      end
    endfunction

    // Compare one output transfer with the oldest prediction.
    function void check_utf(utf_t got);
      utf_t want;
      if (utf_q.size() == 0) begin
        $display("%0t: unexpected transfer: byte %02h valid %b run_last %b end %b err %b",
                 $time, got.out_byte, got.byte_valid, got.run_last, got.string_end,
                 got.range_error);
        fails++;
        return;
      end
      want = utf_q.pop_front();
      if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
          got.run_last !== want.run_last || got.string_end !== want.string_end ||
          got.range_error !== want.range_error) begin
        $display("%0t: mismatch: expected byte %02h valid %b run_last %b end %b err %b",
                 $time, want.out_byte, want.byte_valid, want.run_last, want.string_end,
                 want.range_error);
        $display("%0t:           actual byte %02h valid %b run_last %b end %b err %b",
                 $time, got.out_byte, got.byte_valid, got.run_last, got.string_end,
                 got.range_error);
        fails++;
      end
    endfunction
  endclass

  logic  clk;
  logic  rst;
  logic  text_valid;
  text_t text;
  logic  text_stall;
  logic  utf_valid;
  utf_t  utf;
  logic  utf_stall;

  int    send_idle = 0;
  int    recv_idle = 0;

  utf8_decode_pred utf8_pred = new();
  logic [7:0]      str_chars [$];
  text_t           text_q [$];

  unicode_escape_to_utf8 dut (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text       (text),
    .text_stall (text_stall),
    .utf_valid  (utf_valid),
    .utf        (utf),
    .utf_stall  (utf_stall)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit far above the slowest correct run.
  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

  // Receiver backpressure, changed at the falling edge.
  initial begin
    utf_stall = 1'b0;
    forever begin
      @(negedge clk);
      utf_stall = ($urandom_range(99) < recv_idle);
    end
  end

  // Check every output transfer.
  always @(posedge clk) begin
    if (!rst && utf_valid && !utf_stall) utf8_pred.check_utf(utf);
  end

  function automatic void push_char(logic [7:0] c, logic last);
    text_t item;
    item.char_in     = c;
    item.string_last = last;
    text_q.push_back(item);
  endfunction

  function automatic void queue_string(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 10) return "0" + nib;
    if ($urandom_range(1)) return 8'("A" + nib - 10);
    return 8'("a" + nib - 10);
  endfunction

  // Code points spread over every UTF-8 length, plus out-of-range values.
  function automatic logic [31:0] pick_code_point();
    case ($urandom_range(5))
      0: return $urandom_range(32'h7F);
      1: return $urandom_range(32'h80, 32'h7FF);
      2: return $urandom_range(32'h800, 32'hFFFF);
      3: return $urandom_range(32'h1_0000, 32'h10_FFFF);
      4: return $urandom_range(32'h11_0000, 32'hFFFF_FFFF);
      default: begin
        case ($urandom_range(4))
          0: return 32'h0;
          1: return 32'hD800;
          2: return CP_MAX4;
          3: return CP_MAX4 + 1;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
    return c;
  endfunction

  // One random string: hex escapes with random content as the largest share, plus
  // raw bytes, simple escapes and truncated escapes.
  function automatic void build_string();
    int          pieces = $urandom_range(1, 4);
    int          sel;
    int          digits;
    logic [31:0] cp;
    str_chars.delete();
    for (int p = 0; p < pieces; p++) begin
      sel = $urandom_range(99);
      cp  = pick_code_point();
      if (sel < 30) begin
        str_chars.push_back(8'($urandom_range(255)));
      end else if (sel < 75) begin
        digits = (sel < 55) ? 4 : 8;
        str_chars.push_back(CH_BSLASH);
        str_chars.push_back((digits == 4) ? CH_LOWER_U : CH_UPPER_U);
        for (int i = digits - 1; i >= 0; i--) str_chars.push_back(hex_char(cp[4*i +: 4]));
      end else if (sel < 85) begin
        str_chars.push_back(CH_BSLASH);
        case ($urandom_range(2))
          0: str_chars.push_back(CH_QUOTE);
          1: str_chars.push_back(CH_BSLASH);
          default: str_chars.push_back(8'($urandom_range(255)));
        endcase
      end else begin
        digits = $urandom_range(1) ? 4 : 8;
        str_chars.push_back(CH_BSLASH);
        str_chars.push_back((digits == 4) ? CH_LOWER_U : CH_UPPER_U);
        for (int i = $urandom_range(digits - 1); i > 0; i--)
          str_chars.push_back(hex_char(4'($urandom_range(15))));
        if ($urandom_range(1)) str_chars.push_back(non_hex_char());
      end
    end
    foreach (str_chars[i]) push_char(str_chars[i], i == str_chars.size() - 1);
  endfunction

  // Offer one character and hold it until the transfer happens.
  task automatic send_text(input text_t item);
    while ($urandom_range(99) < send_idle) begin
      text_valid = 1'b0;
      @(negedge clk);
    end
    text_valid = 1'b1;
    text       = item;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    utf8_pred.note_text(item);
    @(negedge clk);
  endtask

  task automatic run_phase(input int count);
    int target;
    target = text_q.size() + count;
    while (text_q.size() < target) build_string();
    while (text_q.size() > 0) send_text(text_q.pop_front());
  endtask

  // Main sequence: reset, directed strings, then three idling patterns.
  initial begin
    rst        = 1'b1;
    text_valid = 1'b0;
    text       = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Quote and backslash escapes, a lone zero byte, the top byte value, an
    // out-of-range long escape, a non-hex digit and a string ending mid-escape.
    queue_string("\\'");
    queue_string("\\\\");
    push_char(8'h00, 1'b1);
    push_char(8'hFF, 1'b1);
    queue_string("\\U00110000");
    queue_string("\\u1g");
    queue_string("\\u0");

    send_idle = 14;
    recv_idle = 86;
    run_phase(110);
    send_idle = 86;
    recv_idle = 14;
    run_phase(110);
    send_idle = 0;
    recv_idle = 0;
    run_phase(110);
    text_valid = 1'b0;

    while (utf8_pred.utf_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (utf8_pred.fails == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
